/* hdl/jpeg_dht_canonical_code_gen_unit_macros.svh */
// ----------------------------------------------------------------------------
// JPEG DHT code generator assertion macros
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef JPEG_DHT_CANONICAL_CODE_GEN_UNIT_MACROS_SVH
`define JPEG_DHT_CANONICAL_CODE_GEN_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define JDHT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define JDHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JDHT_ASSERT_SAME(lbl, ante, cons, msg)
`define JDHT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/jdht_pkg.sv */
// ----------------------------------------------------------------------------
// jdht_pkg
// Shared types and constants of the JPEG DHT canonical code generator.
// ----------------------------------------------------------------------------
`default_nettype none

package jdht_pkg;

    localparam int MAX_CODE_BITS = 16;

    localparam logic [7:0]  BYTE_MARK = 8'hFF;
    localparam logic [7:0]  BYTE_DHT  = 8'hC4;
    localparam logic [7:0]  BYTE_SOS  = 8'hDA;
    localparam logic [3:0]  NIB_MASK  = 4'hF;
    localparam logic [16:0] CODE_CAP  = 17'h10000;
    localparam logic [4:0]  LEN_MAX   = 5'd16;
    localparam logic [3:0]  POS_LAST  = 4'd15;

    typedef enum logic [5:0] {
        PH_SCAN   = 6'b000001,
        PH_SKIP   = 6'b000010,
        PH_SEL    = 6'b000100,
        PH_COUNTS = 6'b001000,
        PH_SYMS   = 6'b010000,
        PH_STOP   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [4:0]  cur_len;
        logic [16:0] code_val;
        logic [7:0]  left;
        logic [15:0] nonzero;
    } skip_req_t;

    typedef struct packed {
        logic [4:0]  cur_len;
        logic [16:0] code_val;
        logic [3:0]  idx;
        logic        moved;
    } skip_res_t;

endpackage

`default_nettype wire

/* hdl/jpeg_dht_canonical_code_gen_unit.sv */
// ----------------------------------------------------------------------------
// jpeg_dht_canonical_code_gen_unit
// Scans a JPEG byte stream for DHT segments and emits the canonical Huffman
// code and length of every symbol of each table.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   input    | in_valid / in_stall   | data_byte, new_stream
//   output   | out_valid / out_stall | symbol, code, code_length, table_class,
//            |                       | table_index, last_in_table, bad_selector,
//            |                       | code_overflow
//
// One byte per cycle unless a stalled result holds the input; a symbol's
// byte passes through the input register, then the result register.
// Reset clears parse state and the valid bits of both registers; the count table needs no clear.
// A stalled result only holds up a following byte that itself yields a result.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_dht_canonical_code_gen_unit
    import jdht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        new_stream,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  symbol,
    output logic [15:0] code,
    output logic [4:0]  code_length,
    output logic        table_class,
    output logic [1:0]  table_index,
    output logic        last_in_table,
    output logic        bad_selector,
    output logic        code_overflow
);

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       new_reg;
    logic       accept;
    logic       go;
    logic       can_go;

    assign go = in_valid_reg && can_go;

    assign in_stall = in_valid_reg && !go;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
            new_reg  <= new_stream;
        end
    end

    jdht_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (byte_reg),
        .in_new        (new_reg),
        .go            (go),
        .can_go        (can_go),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .symbol        (symbol),
        .code          (code),
        .code_length   (code_length),
        .table_class   (table_class),
        .table_index   (table_index),
        .last_in_table (last_in_table),
        .bad_selector  (bad_selector),
        .code_overflow (code_overflow)
    );

endmodule

`default_nettype wire

/* hdl/jdht_skip.sv */
// ----------------------------------------------------------------------------
// jdht_skip
// Jumps over empty code lengths in one step: priority encode of the next
// non-empty length and a saturating left shift of the running code.
// ----------------------------------------------------------------------------
`default_nettype none

module jdht_skip
    import jdht_pkg::*;
(
    input  skip_req_t req,
    output skip_res_t res
);

    logic [3:0]  sel_idx;
    logic        found;
    logic [4:0]  tgt_len;
    logic [4:0]  shamt;
    logic [31:0] wide;

    always_comb
    begin
        sel_idx = 4'd15;
        found   = 1'b0;
        // downward scan so the lowest qualifying length wins
        for (int i = 15; i >= 0; i--)
        begin
            if (req.nonzero[i] && (5'(i) >= req.cur_len))
            begin
                sel_idx = 4'(i);
                found   = 1'b1;
            end
        end
        tgt_len = found ? (5'(sel_idx) + 5'd1) : LEN_MAX;
        shamt   = tgt_len - req.cur_len;
        wide    = 32'(req.code_val) << shamt;

        res.moved = (req.left == 8'd0) && (req.cur_len < LEN_MAX);
        if (res.moved)
        begin
            res.cur_len  = tgt_len;
            res.code_val = (wide > 32'(CODE_CAP)) ? CODE_CAP : wide[16:0];
            res.idx      = tgt_len[3:0] - 4'd1;
        end
        else
        begin
            res.cur_len  = req.cur_len;
            res.code_val = req.code_val;
            res.idx      = req.cur_len[3:0] - 4'd1;
        end
    end

endmodule

`default_nettype wire

/* hdl/jdht_core.sv */
// ----------------------------------------------------------------------------
// jdht_core
// Marker scan and DHT parse state, per-symbol code generation and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jpeg_dht_canonical_code_gen_unit_macros.svh"

module jdht_core
    import jdht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  in_byte,
    input  logic        in_new,
    input  logic        go,
    output logic        can_go,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  symbol,
    output logic [15:0] code,
    output logic [4:0]  code_length,
    output logic        table_class,
    output logic [1:0]  table_index,
    output logic        last_in_table,
    output logic        bad_selector,
    output logic        code_overflow
);

    phase_t      phase_reg, phase_next, ph;
    logic        saw_ff_reg, saw_ff_next, ff;
    logic [1:0]  skip_reg, skip_next;
    logic [7:0]  counts_reg [16];
    logic [3:0]  count_pos_reg, count_pos_next;
    logic [4:0]  cur_len_reg, cur_len_next;
    logic [7:0]  left_reg, left_next;
    logic [11:0] syms_left_reg, syms_left_next;
    logic [16:0] code_val_reg, code_val_next;
    logic        class_reg, class_next;
    logic [1:0]  index_reg, index_next;
    logic        sel_bad_reg, sel_bad_next;

    logic        out_valid_reg;
    logic [7:0]  symbol_reg;
    logic [15:0] code_out_reg;
    logic [4:0]  len_out_reg;
    logic        cls_out_reg;
    logic [1:0]  idx_out_reg;
    logic        last_out_reg;
    logic        bad_out_reg;
    logic        ovf_out_reg;

    logic        emit;
    logic        cnt_wr;
    logic [11:0] sum;
    logic        ovf;
    logic        last;
    logic [15:0] code_emit;
    logic [16:0] code_inc;
    logic [16:0] len_mask;
    logic [7:0]  left_dec;
    logic [15:0] nz;
    skip_req_t   sreq;
    skip_res_t   sres;

    jdht_skip u_skip (
        .req (sreq),
        .res (sres)
    );

    always_comb
    begin
        ph = in_new ? PH_SCAN : phase_reg;
        ff = in_new ? 1'b0 : saw_ff_reg;

        for (int i = 0; i < 16; i++)
        begin
            nz[i] = (counts_reg[i] != 8'd0);
        end
        // last count byte is written in the same cycle it is needed
        if (ph == PH_COUNTS)
        begin
            nz[15] = (in_byte != 8'd0);
        end

        sum       = syms_left_reg + 12'(in_byte);
        ovf       = (cur_len_reg > 5'(MAX_CODE_BITS)) ||
                    ((code_val_reg >> cur_len_reg) != 17'd0);
        len_mask  = (17'd1 << cur_len_reg) - 17'd1;
        code_emit = ovf ? len_mask[15:0] : code_val_reg[15:0];
        last      = (syms_left_reg <= 12'd1);
        code_inc  = (code_val_reg == CODE_CAP) ? CODE_CAP : (code_val_reg + 17'd1);
        left_dec  = (left_reg != 8'd0) ? (left_reg - 8'd1) : left_reg;

        if (ph == PH_SYMS)
        begin
            sreq.cur_len  = cur_len_reg;
            sreq.code_val = code_inc;
            sreq.left     = left_dec;
        end
        else
        begin
            sreq.cur_len  = 5'd1;
            sreq.code_val = 17'd0;
            sreq.left     = counts_reg[0];
        end
        sreq.nonzero = nz;

        phase_next     = ph;
        saw_ff_next    = ff;
        skip_next      = skip_reg;
        count_pos_next = count_pos_reg;
        cur_len_next   = cur_len_reg;
        left_next      = left_reg;
        syms_left_next = syms_left_reg;
        code_val_next  = code_val_reg;
        class_next     = class_reg;
        index_next     = index_reg;
        sel_bad_next   = sel_bad_reg;
        emit           = 1'b0;
        cnt_wr         = 1'b0;

        case (ph)
            PH_SCAN:
            begin
                if (ff)
                begin
                    saw_ff_next = 1'b0;
                    if (in_byte == BYTE_SOS)
                    begin
                        phase_next = PH_STOP;
                    end
                    else if (in_byte == BYTE_DHT)
                    begin
                        phase_next = PH_SKIP;
                        skip_next  = 2'd2;
                    end
                end
                else if (in_byte == BYTE_MARK)
                begin
                    saw_ff_next = 1'b1;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 2'd1;
                if (skip_next == 2'd0)
                begin
                    phase_next = PH_SEL;
                end
            end
            PH_SEL:
            begin
                sel_bad_next   = ((in_byte[7:4] & NIB_MASK) > 4'd1) ||
                                 ((in_byte[3:0] & NIB_MASK) > 4'd3);
                class_next     = in_byte[4];
                index_next     = in_byte[1:0];
                count_pos_next = 4'd0;
                syms_left_next = 12'd0;
                phase_next     = PH_COUNTS;
            end
            PH_COUNTS:
            begin
                cnt_wr         = 1'b1;
                syms_left_next = sum;
                if (count_pos_reg == POS_LAST)
                begin
                    count_pos_next = 4'd0;
                    if (sum == 12'd0)
                    begin
                        phase_next = PH_SCAN;
                    end
                    else
                    begin
                        cur_len_next  = sres.cur_len;
                        code_val_next = sres.code_val;
                        left_next     = sres.moved ?
                                        ((sres.idx == POS_LAST) ? in_byte :
                                                                  counts_reg[sres.idx]) :
                                        counts_reg[0];
                        phase_next    = PH_SYMS;
                    end
                end
                else
                begin
                    count_pos_next = count_pos_reg + 4'd1;
                end
            end
            PH_SYMS:
            begin
                emit          = 1'b1;
                code_val_next = code_inc;
                left_next     = left_dec;
                if (last)
                begin
                    syms_left_next = 12'd0;
                    phase_next     = PH_SCAN;
                end
                else
                begin
                    syms_left_next = syms_left_reg - 12'd1;
                    cur_len_next   = sres.cur_len;
                    code_val_next  = sres.code_val;
                    if (sres.moved)
                    begin
                        left_next = counts_reg[sres.idx];
                    end
                end
            end
            PH_STOP:
            begin
                phase_next = PH_STOP;
            end
            default:
            begin
                phase_next = PH_SCAN;
            end
        endcase

        // a request that yields no result never waits on the output side
        can_go = !emit || !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SCAN;
            saw_ff_reg    <= 1'b0;
            skip_reg      <= 2'd0;
            count_pos_reg <= 4'd0;
            cur_len_reg   <= 5'd1;
            left_reg      <= 8'd0;
            syms_left_reg <= 12'd0;
            code_val_reg  <= 17'd0;
            class_reg     <= 1'b0;
            index_reg     <= 2'd0;
            sel_bad_reg   <= 1'b0;
        end
        else if (go)
        begin
            phase_reg     <= phase_next;
            saw_ff_reg    <= saw_ff_next;
            skip_reg      <= skip_next;
            count_pos_reg <= count_pos_next;
            cur_len_reg   <= cur_len_next;
            left_reg      <= left_next;
            syms_left_reg <= syms_left_next;
            code_val_reg  <= code_val_next;
            class_reg     <= class_next;
            index_reg     <= index_next;
            sel_bad_reg   <= sel_bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && cnt_wr)
        begin
            counts_reg[count_pos_reg] <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            symbol_reg   <= in_byte;
            code_out_reg <= code_emit;
            len_out_reg  <= cur_len_reg;
            cls_out_reg  <= class_reg;
            idx_out_reg  <= index_reg;
            last_out_reg <= last;
            bad_out_reg  <= sel_bad_reg;
            ovf_out_reg  <= ovf;
        end
    end

    assign out_valid     = out_valid_reg;
    assign symbol        = symbol_reg;
    assign code          = code_out_reg;
    assign code_length   = len_out_reg;
    assign table_class   = cls_out_reg;
    assign table_index   = idx_out_reg;
    assign last_in_table = last_out_reg;
    assign bad_selector  = bad_out_reg;
    assign code_overflow = ovf_out_reg;

    `JDHT_ASSERT_SAME(a_syms_pending, phase_reg == PH_SYMS, syms_left_reg != 12'd0,
                      "symbol phase with nothing left")
    `JDHT_ASSERT_SAME(a_len_range, phase_reg == PH_SYMS,
                      (cur_len_reg != 5'd0) && (cur_len_reg <= LEN_MAX),
                      "code length out of range")
    `JDHT_ASSERT_SAME(a_code_sat, code_val_reg[16], code_val_reg[15:0] == 16'd0,
                      "running code above saturation cap")
    `JDHT_ASSERT_NEXT(a_last_ends, go && emit && last, phase_reg == PH_SCAN,
                      "last symbol did not end table")
    `JDHT_ASSERT_NEXT(a_emit_loads, go && emit, out_valid_reg, "emitted symbol lost")

endmodule

`default_nettype wire

/* bench/jpeg_dht_canonical_code_gen_unit_tb.sv */
// ----------------------------------------------------------------------------
// jpeg_dht_canonical_code_gen_unit_tb
// Feeds JPEG-like byte streams (DHT segments, SOS stops, restarts, noise) into
// the code generator, predicts each canonical code in a cycle-free model and
// compares every emitted result field by field, with random idling on both
// channels.
// ----------------------------------------------------------------------------
module jpeg_dht_canonical_code_gen_unit_tb import jdht_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 700;

    typedef struct {
        logic [7:0] value;
        logic       restart;
        logic       wait_drain;
    } file_byte_t;

    typedef struct {
        logic [7:0]  symbol;
        logic [15:0] code;
        logic [4:0]  length;
        logic        cls;
        logic [1:0]  index;
        logic        last;
        logic        bad;
        logic        ovf;
    } huff_code_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        new_stream = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  symbol;
    logic [15:0] code;
    logic [4:0]  code_length;
    logic        table_class;
    logic [1:0]  table_index;
    logic        last_in_table;
    logic        bad_selector;
    logic        code_overflow;

    file_byte_t  file_bytes[$];
    huff_code_t  pending_codes[$];

    // stimulus building
    logic [7:0]  seg_counts[16];
    logic [7:0]  fixed_syms[$];
    int          n_table_bytes = 0;

    // predicted parser state
    phase_t      scan_phase;
    logic        saw_mark;
    logic [1:0]  len_skip;
    logic [7:0]  cnt_tab[16];
    logic [3:0]  cnt_pos;
    logic [4:0]  cur_len;
    logic [7:0]  len_left;
    logic [11:0] sym_left;
    logic [16:0] code_acc;
    logic        tab_class;
    logic [1:0]  tab_index;
    logic        sel_bad;

    int          n_bytes_in = 0;
    int          n_codes = 0;
    int          n_tables = 0;
    int          n_ovf = 0;
    int          n_bad = 0;
    int          n_len16 = 0;
    int          n_errors = 0;

    int          cyc;
    int          hold_left;
    logic        hold_done;
    logic        quiet;

    jpeg_dht_canonical_code_gen_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .new_stream    (new_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .symbol        (symbol),
        .code          (code),
        .code_length   (code_length),
        .table_class   (table_class),
        .table_index   (table_index),
        .last_in_table (last_in_table),
        .bad_selector  (bad_selector),
        .code_overflow (code_overflow)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ---------------- code predictor ----------------

    task automatic reset_parser();
        scan_phase = PH_SCAN;
        saw_mark   = 1'b0;
        len_skip   = 2'd0;
        foreach (cnt_tab[i])
            cnt_tab[i] = 8'd0;
        cnt_pos    = 4'd0;
        cur_len    = 5'd1;
        len_left   = 8'd0;
        sym_left   = 12'd0;
        code_acc   = 17'd0;
        tab_class  = 1'b0;
        tab_index  = 2'd0;
        sel_bad    = 1'b0;
    endtask

    // step to the next length with symbols left; code doubles per step, saturating
    task automatic next_nonempty_length();
        logic [17:0] dbl;
        while (len_left == 8'd0 && cur_len < LEN_MAX)
        begin
            cur_len  = cur_len + 5'd1;
            dbl      = {code_acc, 1'b0};
            code_acc = (dbl > CODE_CAP) ? CODE_CAP : dbl[16:0];
            len_left = cnt_tab[cur_len - 5'd1];
        end
    endtask

    task automatic predict_byte(input logic [7:0] fb, input logic restart);
        huff_code_t  r;
        logic [17:0] inc;
        if (restart)
        begin
            scan_phase = PH_SCAN;
            saw_mark   = 1'b0;
        end
        case (scan_phase)
            PH_SCAN:
            begin
                if (saw_mark)
                begin
                    // byte after FF is always the marker code, even FF itself
                    saw_mark = 1'b0;
                    if (fb == BYTE_SOS)
                        scan_phase = PH_STOP;
                    else if (fb == BYTE_DHT)
                    begin
                        scan_phase = PH_SKIP;
                        len_skip   = 2'd2;
                    end
                end
                else if (fb == BYTE_MARK)
                    saw_mark = 1'b1;
            end
            PH_SKIP:
            begin
                len_skip = len_skip - 2'd1;
                if (len_skip == 2'd0)
                    scan_phase = PH_SEL;
            end
            PH_SEL:
            begin
                sel_bad    = (fb[7:4] > 4'd1) || (fb[3:0] > 4'd3);
                tab_class  = fb[4];
                tab_index  = fb[1:0];
                cnt_pos    = 4'd0;
                sym_left   = 12'd0;
                scan_phase = PH_COUNTS;
            end
            PH_COUNTS:
            begin
                cnt_tab[cnt_pos] = fb;
                sym_left = sym_left + {4'd0, fb};
                if (cnt_pos == POS_LAST)
                begin
                    cnt_pos = 4'd0;
                    if (sym_left == 12'd0)
                        scan_phase = PH_SCAN;
                    else
                    begin
                        code_acc = 17'd0;
                        cur_len  = 5'd1;
                        len_left = cnt_tab[0];
                        next_nonempty_length();
                        scan_phase = PH_SYMS;
                    end
                end
                else
                    cnt_pos = cnt_pos + 4'd1;
            end
            PH_SYMS:
            begin
                r.ovf    = (cur_len > 5'(MAX_CODE_BITS)) || ((code_acc >> cur_len) != 17'd0);
                r.code   = r.ovf ? 16'((32'd1 << cur_len) - 32'd1) : code_acc[15:0];
                r.symbol = fb;
                r.length = cur_len;
                r.cls    = tab_class;
                r.index  = tab_index;
                r.last   = (sym_left <= 12'd1);
                r.bad    = sel_bad;
                pending_codes.push_back(r);
                inc      = {1'b0, code_acc} + 18'd1;
                code_acc = (inc > CODE_CAP) ? CODE_CAP : inc[16:0];
                if (len_left != 8'd0)
                    len_left = len_left - 8'd1;
                if (r.last)
                begin
                    sym_left   = 12'd0;
                    scan_phase = PH_SCAN;
                end
                else
                begin
                    sym_left = sym_left - 12'd1;
                    next_nonempty_length();
                end
            end
            default:
                ;
        endcase
    endtask

    // ---------------- stimulus ----------------

    task automatic queue_byte(input logic [7:0] v, input logic rs, input logic hold);
        file_byte_t fb;
        fb.value      = v;
        fb.restart    = rs;
        fb.wait_drain = hold;
        file_bytes.push_back(fb);
    endtask

    task automatic clear_counts();
        foreach (seg_counts[i])
            seg_counts[i] = 8'd0;
    endtask

    // FF C4, two length bytes, selector, counts, symbols; cut > 0 truncates
    task automatic queue_table(input logic [7:0] sel, input int cut, input logic rs,
                               input logic hold);
        logic [7:0] seg[$];
        int         total;
        total = 0;
        seg.push_back(BYTE_MARK);
        seg.push_back(BYTE_DHT);
        seg.push_back(8'($urandom_range(0, 255)));
        seg.push_back(8'($urandom_range(0, 255)));
        seg.push_back(sel);
        foreach (seg_counts[i])
        begin
            seg.push_back(seg_counts[i]);
            total += seg_counts[i];
        end
        for (int i = 0; i < total; i++)
        begin
            if (fixed_syms.size() != 0)
                seg.push_back(fixed_syms.pop_front());
            else
                seg.push_back(8'($urandom_range(0, 255)));
        end
        if (cut <= 0 || cut > seg.size())
            cut = seg.size();
        for (int i = 0; i < cut; i++)
            queue_byte(seg[i], rs && i == 0, hold && i == 0);
        n_table_bytes += cut;
    endtask

    task automatic random_counts();
        int pick;
        pick = $urandom_range(0, 9);
        clear_counts();
        if (pick < 7)
            repeat ($urandom_range(1, 3))
                seg_counts[$urandom_range(0, 15)] = 8'($urandom_range(1, 3));
        else if (pick == 7)
            seg_counts[$urandom_range(0, 3)] = 8'($urandom_range(3, 12));
        else if (pick == 8)
            foreach (seg_counts[i])
                seg_counts[i] = 8'($urandom_range(0, 2));
        // pick 9: empty table
    endtask

    function automatic logic [7:0] rand_sel();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return {3'b000, 1'($urandom_range(0, 1)), 2'b00, 2'($urandom_range(0, 3))};
    endfunction

    task automatic build_stream();
        int   start;
        int   iter;
        int   kind;
        logic hold;

        // directed: three short codes with marker bytes as symbols
        queue_byte(8'h00, 1'b1, 1'b0);
        clear_counts();
        seg_counts[1] = 8'd2;
        seg_counts[2] = 8'd1;
        fixed_syms.push_back(BYTE_MARK);
        fixed_syms.push_back(BYTE_DHT);
        fixed_syms.push_back(BYTE_SOS);
        queue_table(8'h00, 0, 1'b0, 1'b0);
        // FF FF C4 is not a DHT marker
        queue_byte(BYTE_MARK, 1'b0, 1'b0);
        queue_byte(BYTE_MARK, 1'b0, 1'b0);
        queue_byte(BYTE_DHT, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h01, 1'b0, 1'b0);
        // bad selector, single 16-bit code
        clear_counts();
        seg_counts[15] = 8'd1;
        queue_table(8'h25, 0, 1'b0, 1'b0);
        // overflow at length 1, then saturated at length 16
        clear_counts();
        seg_counts[0]  = 8'd3;
        seg_counts[15] = 8'd2;
        queue_table(8'h13, 0, 1'b0, 1'b0);
        // empty table
        clear_counts();
        queue_table(8'h11, 0, 1'b0, 1'b0);
        // SOS stops parsing; a DHT after it is ignored until restart
        queue_byte(BYTE_MARK, 1'b0, 1'b0);
        queue_byte(BYTE_SOS, 1'b0, 1'b0);
        queue_byte(BYTE_MARK, 1'b0, 1'b0);
        queue_byte(BYTE_DHT, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        clear_counts();
        seg_counts[7]  = 8'd1;
        seg_counts[15] = 8'd1;
        queue_table(8'hF0, 0, 1'b1, 1'b1);

        start = n_table_bytes;
        iter  = 0;
        while (n_table_bytes - start < RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 99);
            hold = (iter % 37 == 18);
            if (iter == 5)
            begin
                // largest count once
                clear_counts();
                seg_counts[15] = 8'd255;
                queue_table(8'h01, 0, 1'b0, hold);
            end
            else if (kind < 60)
            begin
                random_counts();
                queue_table(rand_sel(), 0, $urandom_range(0, 19) == 0, hold);
            end
            else if (kind < 70)
            begin
                // segment cut short by a new file
                random_counts();
                queue_table(rand_sel(), $urandom_range(1, 25), 1'b0, hold);
                queue_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            else if (kind < 80)
            begin
                repeat ($urandom_range(1, 6))
                    queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0);
            end
            else if (kind < 88)
            begin
                queue_byte(BYTE_MARK, 1'b0, hold);
                queue_byte(BYTE_SOS, 1'b0, 1'b0);
                repeat ($urandom_range(1, 8))
                    queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                queue_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            else if (kind < 94)
            begin
                queue_byte(BYTE_MARK, 1'b0, hold);
                queue_byte(BYTE_MARK, 1'b0, 1'b0);
                queue_byte(BYTE_DHT, 1'b0, 1'b0);
                queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                n_table_bytes += 3;
            end
            else
            begin
                queue_byte(BYTE_MARK, 1'b0, hold);
                queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                n_table_bytes += 2;
            end
            iter++;
        end
    endtask

    // ---------------- sender ----------------

    always @(posedge clk or negedge rst_n)
    begin
        file_byte_t nxt;
        logic       go;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= 8'd0;
            new_stream <= 1'b0;
            reset_parser();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_byte(data_byte, new_stream);
                n_bytes_in <= n_bytes_in + 1;
            end
            if (!in_valid || !in_stall)
            begin
                go = file_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= 31);
                // drain point: hold off until every pending code has come out
                if (go && file_bytes[0].wait_drain && pending_codes.size() != 0)
                    go = 1'b0;
                if (go)
                begin
                    nxt = file_bytes.pop_front();
                    in_valid   <= 1'b1;
                    data_byte  <= nxt.value;
                    new_stream <= nxt.restart;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endtask

    task automatic check_code();
        huff_code_t e;
        if (pending_codes.size() == 0)
        begin
            $error("code result for symbol 0x%0h with no request pending", symbol);
            n_errors++;
            return;
        end
        e = pending_codes.pop_front();
        check_field("symbol", e.symbol, symbol);
        check_field("code", e.code, code);
        check_field("code_length", e.length, code_length);
        check_field("table_class", e.cls, table_class);
        check_field("table_index", e.index, table_index);
        check_field("last_in_table", e.last, last_in_table);
        check_field("bad_selector", e.bad, bad_selector);
        check_field("code_overflow", e.ovf, code_overflow);
        n_codes++;
        n_tables += e.last;
        n_ovf    += e.ovf;
        n_bad    += e.bad;
        n_len16  += (e.length == LEN_MAX);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                check_code();
            out_stall <= (hold_left != 0) || (!quiet && $urandom_range(0, 99) < 31);
        end
    end

    // cycle count, quiet window and one long output hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc       <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (!hold_done && n_bytes_in >= 300)
            begin
                hold_left <= 200;
                hold_done <= 1'b1;
            end
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    assign quiet = (cyc >= 1200) && (cyc < 1800);

    // ---------------- run control ----------------

    initial
    begin
        build_stream();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (file_bytes.size() != 0 || in_valid)
            @(negedge clk);
        while (pending_codes.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        $display("Sent %0d bytes; checked %0d codes from %0d complete tables.",
                 n_bytes_in, n_codes, n_tables);
        $display("Codes with overflow: %0d, bad selector: %0d, 16-bit length: %0d.",
                 n_ovf, n_bad, n_len16);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: %0d codes still pending, %0d bytes unsent.",
                 pending_codes.size(), file_bytes.size());
        $display("FAIL");
        $finish;
    end

endmodule
